@@ sv/angle_gyro_kalman_fusion_assert.svh @@
// Assertion macros for the angle/gyro Kalman fusion block.
// Used by the top level; no other dependencies.
`ifndef ANGLE_GYRO_KALMAN_FUSION_ASSERT_SVH
`define ANGLE_GYRO_KALMAN_FUSION_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset
`define AGKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define AGKF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AGKF_ASSERT(lbl, prop, msg)
`define AGKF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ sv/agkf_pkg.sv @@
// Shared types, operation codes and saturation helpers for the Kalman fusion block.
// No dependencies.
package agkf_pkg;

  // sequencer operation codes, in issue order
  localparam logic [4:0] OP_ANG = 5'd0;
  localparam logic [4:0] OP_P0  = 5'd1;
  localparam logic [4:0] OP_P1  = 5'd2;
  localparam logic [4:0] OP_P2  = 5'd3;
  localparam logic [4:0] OP_P3  = 5'd4;
  localparam logic [4:0] OP_PC0 = 5'd5;
  localparam logic [4:0] OP_PC1 = 5'd6;
  localparam logic [4:0] OP_E   = 5'd7;
  localparam logic [4:0] OP_K0  = 5'd8;
  localparam logic [4:0] OP_K1  = 5'd9;
  localparam logic [4:0] OP_B2  = 5'd10;
  localparam logic [4:0] OP_A2  = 5'd11;
  localparam logic [4:0] OP_T1  = 5'd12;
  localparam logic [4:0] OP_Q0  = 5'd13;
  localparam logic [4:0] OP_Q1  = 5'd14;
  localparam logic [4:0] OP_Q2  = 5'd15;
  localparam logic [4:0] OP_Q3  = 5'd16;

  // configuration register indexes
  localparam logic [2:0] CFG_TIME_STEP     = 3'd0;
  localparam logic [2:0] CFG_ANGLE_NOISE   = 3'd1;
  localparam logic [2:0] CFG_BIAS_NOISE    = 3'd2;
  localparam logic [2:0] CFG_MEASURE_NOISE = 3'd3;
  localparam logic [2:0] CFG_MEASURE_GAIN  = 3'd4;

  localparam logic signed [63:0] WMAX   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] P_MAX  = 64'sh0000_007F_FFFF_FFFF;
  localparam logic signed [63:0] P_MIN  = -64'sh0000_0080_0000_0000;
  localparam logic signed [63:0] S32MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic       load_in;
    logic       mul_start;
    logic       div_start;
    logic       wb;
    logic       out_load;
    logic [4:0] op;
  } agkf_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic bad;
    logic out_free;
  } agkf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > S32MAX) ? S32MAX : ((v < S32MIN) ? S32MIN : v);
    return c[31:0];
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > P_MAX) ? P_MAX : ((v < P_MIN) ? P_MIN : v);
    return c[39:0];
  endfunction

  function automatic logic signed [63:0] satw(input logic signed [63:0] v);
    return (v > WMAX) ? WMAX : ((v < -WMAX) ? -WMAX : v);
  endfunction

endpackage

@@ sv/agkf_if.sv @@
// Channel interfaces of the Kalman fusion block: sample in, result out, config write.
// No dependencies.
interface agkf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  modport source (output valid, measured_angle, gyro_rate, input ready);
  modport sink (input valid, measured_angle, gyro_rate, output ready);
endinterface

interface agkf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] filtered_rate;
  logic               bad_denominator;
  modport source (output valid, filtered_angle, filtered_rate, bad_denominator, input ready);
  modport sink (input valid, filtered_angle, filtered_rate, bad_denominator, output ready);
endinterface

interface agkf_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [38:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/agkf_mul.sv @@
// Sequential signed multiplier: 64x8 partial product a cycle, round and saturate.
// Depends on agkf_pkg.
module agkf_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [40:0] b_i,
  input  logic               s16_i,
  output logic               done_o,
  output logic signed [63:0] p_o
);
  import agkf_pkg::*;

  logic [63:0]  ua_q, ua_d;
  logic [39:0]  ub_q, ub_d;
  logic [103:0] acc_q, acc_d;
  logic [2:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d, neg_q, neg_d, s16_q, s16_d;
  logic signed [63:0] p_q, p_d;
  logic [40:0]  ubm;
  logic [71:0]  pp;
  logic [104:0] rnd, rsh;
  logic [61:0]  mag;

  assign ubm = b_i[40] ? 41'(-b_i) : 41'(b_i);
  assign pp  = 72'(ua_q) * 72'(ub_q[39:32]);
  assign rnd = {1'b0, acc_q} + (s16_q ? 105'(1) << 15 : 105'(1) << 31);
  assign rsh = s16_q ? (rnd >> 16) : (rnd >> 32);
  assign mag = (|rsh[104:62]) ? WMAX[61:0] : rsh[61:0];

  // byte-serial accumulate, MSB first, then a rounding step
  always_comb begin
    ua_d = ua_q; ub_d = ub_q; acc_d = acc_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; neg_d = neg_q; s16_d = s16_q; p_d = p_q;
    if (start_i) begin
      ua_d   = a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_d   = ubm[39:0];
      neg_d  = a_i[63] ^ b_i[40];
      s16_d  = s16_i;
      acc_d  = '0;
      cnt_d  = 3'd5;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q != 3'd0) begin
        acc_d = (acc_q << 8) + 104'(pp);
        ub_d  = ub_q << 8;
        cnt_d = cnt_q - 3'd1;
      end else begin
        p_d    = neg_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q <= ua_d; ub_q <= ub_d; acc_q <= acc_d;
    neg_q <= neg_d; s16_q <= s16_d; p_q <= p_d;
  end

  assign done_o = done_q;
  assign p_o    = p_q;
endmodule

@@ sv/agkf_div.sv @@
// Restoring divider for the gains: (n * 2^32) / e, one quotient bit a cycle.
// Depends on agkf_pkg.
module agkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] n_i,
  input  logic signed [63:0] e_i,
  output logic               done_o,
  output logic signed [39:0] q_o
);
  import agkf_pkg::*;

  logic [62:0] r_q, r_d, ue_q, ue_d;
  logic [38:0] d_q, d_d, q_q, q_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, neg_q, neg_d;
  logic signed [39:0] res_q, res_d;
  logic [62:0] un;
  logic        ovf;
  logic [63:0] rs;
  logic        qb;
  logic [38:0] qn;

  assign un  = n_i[63] ? 63'(-n_i) : 63'(n_i);
  assign ovf = {7'd0, un} >= {e_i[62:0], 7'd0};
  assign rs  = {r_q, d_q[38]};
  assign qb  = rs >= {1'b0, ue_q};
  assign qn  = {q_q[37:0], qb};

  always_comb begin
    r_d = r_q; ue_d = ue_q; d_d = d_q; q_d = q_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0; neg_d = neg_q; res_d = res_q;
    if (start_i) begin
      neg_d = n_i[63];
      ue_d  = e_i[62:0];
      if (ovf) begin
        // integer part too large: clamp the gain magnitude
        res_d  = n_i[63] ? -P_MAX[39:0] : P_MAX[39:0];
        done_d = 1'b1;
      end else begin
        r_d    = 63'(un >> 7);
        d_d    = {un[6:0], 32'd0};
        q_d    = '0;
        cnt_d  = 6'd39;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      r_d   = qb ? 63'(rs - {1'b0, ue_q}) : rs[62:0];
      d_d   = d_q << 1;
      q_d   = qn;
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        res_d  = neg_q ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
        done_d = 1'b1;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d; ue_q <= ue_d; d_q <= d_d; q_q <= q_d;
    neg_q <= neg_d; res_q <= res_d;
  end

  assign done_o = done_q;
  assign q_o    = res_q;
endmodule

@@ sv/agkf_ctrl.sv @@
// Sequencer of the Kalman fusion block: steps the datapath through one update.
// Depends on agkf_pkg.
module agkf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  agkf_pkg::agkf_sts_t sts_i,
  output agkf_pkg::agkf_cmd_t cmd_o
);
  import agkf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  logic [4:0] op_q, op_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d    = OP_ANG;
          state_d = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd_o.mul_start = 1'b1;
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts_i.mul_done) begin
          cmd_o.wb = 1'b1;
          if (op_q == OP_E) begin
            state_d = S_CHECK;
          end else if (op_q == OP_Q3) begin
            state_d = S_OUT;
          end else begin
            op_d    = op_q + 5'd1;
            state_d = S_MSTART;
          end
        end
      end
      S_CHECK: begin
        // skip the correction on a non-positive innovation variance
        if (sts_i.bad) begin
          state_d = S_OUT;
        end else begin
          op_d    = OP_K0;
          state_d = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.wb = 1'b1;
          if (op_q == OP_K0) begin
            op_d    = OP_K1;
            state_d = S_DSTART;
          end else begin
            op_d    = OP_B2;
            state_d = S_MSTART;
          end
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_ANG;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

@@ sv/agkf_dpath.sv @@
// Datapath of the Kalman fusion block: config, filter state, operand select,
// shared multiplier and divider, result register. Depends on agkf_pkg, agkf_mul, agkf_div.
module agkf_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [38:0]         cfg_data_i,
  input  logic signed [31:0]  meas_i,
  input  logic signed [31:0]  gyro_i,
  input  agkf_pkg::agkf_cmd_t cmd_i,
  output agkf_pkg::agkf_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  out_angle_o,
  output logic signed [31:0]  out_rate_o,
  output logic                out_bad_o
);
  import agkf_pkg::*;

  // configuration
  logic [31:0]        dt_q;
  logic [38:0]        an_q, bn_q, rn_q;
  logic signed [31:0] c0_q;

  // filter state and intermediates
  logic signed [31:0] ang_q, bias_q, meas_q, gyro_q;
  logic signed [39:0] p0_q, p1_q, p2_q, p3_q, k0_q, k1_q;
  logic signed [63:0] pct0_q, pct1_q, t1_q, e_q;
  logic               bad_q;

  // result register
  logic               ov_q;
  logic signed [31:0] oa_q, or_q;
  logic               ob_q;

  logic signed [63:0] ma, prod, esum, esat, dn;
  logic signed [40:0] mb;
  logic               s16, mdone, ddone;
  logic signed [39:0] dq;
  logic signed [32:0] err, rate;

  assign err  = 33'(meas_q) - 33'(ang_q);
  assign rate = 33'(gyro_q) - 33'(bias_q);
  assign esum = $signed({25'd0, rn_q}) + prod;
  assign esat = satw(esum);
  assign dn   = (cmd_i.op == OP_K0) ? pct0_q : pct1_q;

  // operand select per operation
  always_comb begin
    ma  = 64'(rate);
    mb  = $signed({9'd0, dt_q});
    s16 = 1'b0;
    case (cmd_i.op)
      OP_ANG: ma = 64'(rate);
      OP_P0:  ma = $signed({25'd0, an_q}) - 64'(p1_q) - 64'(p2_q);
      OP_P1:  ma = -64'(p3_q);
      OP_P2:  ma = -64'(p3_q);
      OP_P3:  ma = $signed({25'd0, bn_q});
      OP_PC0: begin ma = 64'(p0_q); mb = 41'(c0_q); s16 = 1'b1; end
      OP_PC1: begin ma = 64'(p2_q); mb = 41'(c0_q); s16 = 1'b1; end
      OP_E:   begin ma = pct0_q; mb = 41'(c0_q); s16 = 1'b1; end
      OP_T1:  begin ma = 64'(p1_q); mb = 41'(c0_q); s16 = 1'b1; end
      OP_B2:  begin ma = 64'(err); mb = 41'(k1_q); end
      OP_A2:  begin ma = 64'(err); mb = 41'(k0_q); end
      OP_Q0:  begin ma = pct0_q; mb = 41'(k0_q); end
      OP_Q1:  begin ma = t1_q; mb = 41'(k0_q); end
      OP_Q2:  begin ma = pct0_q; mb = 41'(k1_q); end
      OP_Q3:  begin ma = t1_q; mb = 41'(k1_q); end
      default: ma = 64'(rate);
    endcase
  end

  agkf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (ma),
    .b_i     (mb),
    .s16_i   (s16),
    .done_o  (mdone),
    .p_o     (prod)
  );

  agkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .n_i     (dn),
    .e_i     (e_q),
    .done_o  (ddone),
    .q_o     (dq)
  );

  // config writes and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q   <= 32'd21474836;
      an_q   <= 39'd4294967;
      bn_q   <= 39'd12884902;
      rn_q   <= 39'd2147483648;
      c0_q   <= 32'sd65536;
      ang_q  <= '0;
      bias_q <= '0;
      p0_q   <= 40'sh01_0000_0000;
      p1_q   <= '0;
      p2_q   <= '0;
      p3_q   <= 40'sh01_0000_0000;
      bad_q  <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_TIME_STEP:     dt_q <= cfg_data_i[31:0];
          CFG_ANGLE_NOISE:   an_q <= cfg_data_i;
          CFG_BIAS_NOISE:    bn_q <= cfg_data_i;
          CFG_MEASURE_NOISE: rn_q <= cfg_data_i;
          CFG_MEASURE_GAIN:  c0_q <= $signed(cfg_data_i[31:0]);
          default: ;
        endcase
      end
      if (cmd_i.load_in) bad_q <= 1'b0;
      if (cmd_i.wb) begin
        case (cmd_i.op)
          OP_ANG: ang_q  <= sat32(64'(ang_q) + prod);
          OP_P0:  p0_q   <= sat40(64'(p0_q) + prod);
          OP_P1:  p1_q   <= sat40(64'(p1_q) + prod);
          OP_P2:  p2_q   <= sat40(64'(p2_q) + prod);
          OP_P3:  p3_q   <= sat40(64'(p3_q) + prod);
          OP_E:   bad_q  <= (esat <= 64'sd0);
          OP_B2:  bias_q <= sat32(64'(bias_q) + prod);
          OP_A2:  ang_q  <= sat32(64'(ang_q) + prod);
          OP_Q0:  p0_q   <= sat40(64'(p0_q) - prod);
          OP_Q1:  p1_q   <= sat40(64'(p1_q) - prod);
          OP_Q2:  p2_q   <= sat40(64'(p2_q) - prod);
          OP_Q3:  p3_q   <= sat40(64'(p3_q) - prod);
          default: ;
        endcase
      end
      // result register: hold until taken
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // intermediates and captured payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      meas_q <= meas_i;
      gyro_q <= gyro_i;
    end
    if (cmd_i.wb) begin
      case (cmd_i.op)
        OP_PC0: pct0_q <= prod;
        OP_PC1: pct1_q <= prod;
        OP_E:   e_q    <= esat;
        OP_T1:  t1_q   <= prod;
        OP_K0:  k0_q   <= dq;
        OP_K1:  k1_q   <= dq;
        default: ;
      endcase
    end
    if (cmd_i.out_load) begin
      oa_q <= ang_q;
      or_q <= sat32(64'(rate));
      ob_q <= bad_q;
    end
  end

  assign sts_o.mul_done = mdone;
  assign sts_o.div_done = ddone;
  assign sts_o.bad      = bad_q;
  assign sts_o.out_free = !ov_q || out_ready_i;

  assign out_valid_o = ov_q;
  assign out_angle_o = oa_q;
  assign out_rate_o  = or_q;
  assign out_bad_o   = ob_q;
endmodule

@@ sv/angle_gyro_kalman_fusion.sv @@
// Two-state (angle, gyro bias) Kalman filter for one IMU axis.
// Channels: in_i takes a request of measured angle and gyro rate; out_i
// returns filtered angle, filtered rate and a bad-denominator flag, one
// result per request; cfg_i writes the five filter registers by index and
// is always ready (write only while the block is idle).
// Throughput: one request at a time. A request is taken only when the
// sequencer is idle; after acceptance the result is loaded into the output
// register once the full update is done, or after the prediction alone when
// the innovation variance is not positive and the correction is skipped.
// The time is set by the shared 64x8 multiplier (15 products, 8 when the
// correction is skipped) and the one-bit-a-cycle gain divider (2 quotients,
// each clamped without iterating when the gain saturates).
// A finished result waits in the output register while the next request
// is taken; if the receiver still stalls when the next result is done, the
// sequencer holds until the register is free.
// Reset: config returns to its defaults, angle and bias to zero, the
// covariance to identity, and no result is pending.
module angle_gyro_kalman_fusion (
  input  logic     clk_i,
  input  logic     rst_ni,
  agkf_in_if.sink    in_i,
  agkf_out_if.source out_i,
  agkf_cfg_if.sink   cfg_i
);
  import agkf_pkg::*;
  `include "angle_gyro_kalman_fusion_assert.svh"

  agkf_cmd_t cmd;
  agkf_sts_t sts;
  logic      in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  agkf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  agkf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .meas_i      (in_i.measured_angle),
    .gyro_i      (in_i.gyro_rate),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_i.valid),
    .out_ready_i (out_i.ready),
    .out_angle_o (out_i.filtered_angle),
    .out_rate_o  (out_i.filtered_rate),
    .out_bad_o   (out_i.bad_denominator)
  );

  // one request in flight: no back-to-back acceptance
  `AGKF_ASSERT(a_one_in_flight, in_i.valid && in_i.ready |=> !in_i.ready, "second request taken")
  // the multiplier and divider are never started together
  `AGKF_ASSERT(a_unit_excl, !(cmd.mul_start && cmd.div_start), "mul and div started together")
  // a new result appears only after the sequencer loads it
  `AGKF_ASSERT(a_out_src, $rose(out_i.valid) |-> $past(cmd.out_load), "result without load")
  // nothing pending while in reset
  `AGKF_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_i.valid, "result valid in reset")
endmodule

@@ tb/angle_gyro_kalman_fusion_tb.sv @@
// Self-checking testbench for the angle/gyro Kalman fusion block.
// Depends on agkf_pkg, the channel interfaces in agkf_if.sv and the block itself.
// A cycle-free model of the filter predicts each result the table does not give; stimulus is a directed
// table followed by random samples under several filter settings.
module angle_gyro_kalman_fusion_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import agkf_pkg::*;

  localparam int          IDLE_LIMIT   = 20000;
  localparam int          SETTLE_CYCLES = 250;
  localparam int          PHASES       = 8;
  localparam int          ITEMS_PER_PHASE = 140;
  localparam logic [2:0]  CFG_SPARE_LO = 3'd5;
  localparam logic [2:0]  CFG_SPARE_HI = 3'd7;
  localparam longint      ONE_Q32      = 64'sd1 << 32;
  localparam longint      Q40_MAX      = 64'sh7F_FFFF_FFFF;
  localparam longint      Q40_MIN      = -64'sh80_0000_0000;
  localparam longint      I32_MAX      = 64'sh7FFF_FFFF;
  localparam longint      I32_MIN      = -64'sh8000_0000;
  localparam longint      WIDE_MAX     = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic               bad;
  } fused_t;

  typedef struct {
    logic signed [31:0] meas;
    logic signed [31:0] gyro;
    bit                 typed;
    fused_t             res;
  } sample_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  agkf_in_if  in_ch ();
  agkf_out_if out_ch ();
  agkf_cfg_if cfg_ch ();

  angle_gyro_kalman_fusion dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_i  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  // filter state and settings as the block should hold them
  longint dt_q, qa_q, qb_q, rn_q, c0_q;
  longint ang_q, bias_q;
  longint cov_q [4];

  fused_t pending_results [$];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     stall_pct = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // exact product, rounded half away from zero, then saturated
  function automatic longint mul_round(longint a, longint b, int s);
    logic [127:0] prod;
    logic [63:0]  ua, ub;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    ua   = a < 0 ? -a : a;
    ub   = b < 0 ? -b : b;
    prod = {64'd0, ua} * {64'd0, ub};
    prod = prod + (128'd1 << (s - 1));
    prod = prod >> s;
    if (prod > WIDE_MAX) prod = WIDE_MAX;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // gain = num * 2^32 / den, truncated, magnitude capped at 2^39-1
  function automatic longint gain_div(longint num, longint den);
    logic [127:0] q;
    logic [63:0]  un;
    un = num < 0 ? -num : num;
    if (un / den >= 128) q = Q40_MAX;
    else q = ({64'd0, un} << 32) / den;
    return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic void reset_filter();
    dt_q = 21474836; qa_q = 4294967; qb_q = 12884902; rn_q = 64'sd2147483648; c0_q = 65536;
    ang_q = 0; bias_q = 0;
    cov_q = '{ONE_Q32, 0, 0, ONE_Q32};
  endfunction

  function automatic void apply_setting(logic [2:0] idx, logic [38:0] val);
    case (idx)
      CFG_TIME_STEP:     dt_q = longint'({32'd0, val[31:0]});
      CFG_ANGLE_NOISE:   qa_q = longint'({25'd0, val});
      CFG_BIAS_NOISE:    qb_q = longint'({25'd0, val});
      CFG_MEASURE_NOISE: rn_q = longint'({25'd0, val});
      CFG_MEASURE_GAIN:  c0_q = longint'($signed(val[31:0]));
      default: ;
    endcase
  endfunction

  // one filter step: predict, then correct unless the innovation variance is not positive
  function automatic fused_t fuse_step(logic signed [31:0] meas, logic signed [31:0] gyro);
    longint m, g, d0, d1, pc0, pc1, e, t1, k0, k1, err;
    fused_t r;
    m = meas;
    g = gyro;
    r.bad = 1'b0;
    ang_q = clip(ang_q + mul_round(g - bias_q, dt_q, 32), I32_MIN, I32_MAX);
    d0 = qa_q - cov_q[1] - cov_q[2];
    d1 = -cov_q[3];
    cov_q[0] = clip(cov_q[0] + mul_round(d0, dt_q, 32), Q40_MIN, Q40_MAX);
    cov_q[1] = clip(cov_q[1] + mul_round(d1, dt_q, 32), Q40_MIN, Q40_MAX);
    cov_q[2] = clip(cov_q[2] + mul_round(d1, dt_q, 32), Q40_MIN, Q40_MAX);
    cov_q[3] = clip(cov_q[3] + mul_round(qb_q, dt_q, 32), Q40_MIN, Q40_MAX);
    pc0 = mul_round(c0_q, cov_q[0], 16);
    pc1 = mul_round(c0_q, cov_q[2], 16);
    e = clip(rn_q + mul_round(c0_q, pc0, 16), -WIDE_MAX, WIDE_MAX);
    if (e <= 0) begin
      r.bad = 1'b1;
    end else begin
      k0  = gain_div(pc0, e);
      k1  = gain_div(pc1, e);
      err = m - ang_q;
      ang_q  = clip(ang_q + mul_round(k0, err, 32), I32_MIN, I32_MAX);
      bias_q = clip(bias_q + mul_round(k1, err, 32), I32_MIN, I32_MAX);
      t1 = mul_round(c0_q, cov_q[1], 16);
      cov_q[0] = clip(cov_q[0] - mul_round(k0, pc0, 32), Q40_MIN, Q40_MAX);
      cov_q[1] = clip(cov_q[1] - mul_round(k0, t1, 32), Q40_MIN, Q40_MAX);
      cov_q[2] = clip(cov_q[2] - mul_round(k1, pc0, 32), Q40_MIN, Q40_MAX);
      cov_q[3] = clip(cov_q[3] - mul_round(k1, t1, 32), Q40_MIN, Q40_MAX);
    end
    r.angle = ang_q[31:0];
    r.rate  = 32'(clip(g - bias_q, I32_MIN, I32_MAX));
    return r;
  endfunction

  // receiver: stall rate set per phase
  always @(negedge clk_i) begin
    if (stall_pct == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // result checking against the oldest outstanding prediction
  always @(posedge clk_i) begin
    fused_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle=%0d rate=%0d bad=%0b",
                                       out_ch.filtered_angle, out_ch.filtered_rate,
                                       out_ch.bad_denominator);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.filtered_angle !== want.angle || out_ch.filtered_rate !== want.rate ||
            out_ch.bad_denominator !== want.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp angle=%0d rate=%0d bad=%0b, got angle=%0d rate=%0d bad=%0b",
                     want.angle, want.rate, want.bad, out_ch.filtered_angle,
                     out_ch.filtered_rate, out_ch.bad_denominator);
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [38:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_setting(idx, val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // valid is left high so that back-to-back requests stay in one burst
  task automatic send_sample(logic signed [31:0] meas, logic signed [31:0] gyro,
                             bit typed, fused_t typed_res);
    fused_t r;
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.measured_angle <= meas;
    in_ch.gyro_rate      <= gyro;
    do @(posedge clk_i); while (!in_ch.ready);
    r = fuse_step(meas, gyro);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    hold_off(0);
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  sample_row_t stim_rows [$];

  function automatic void add_row(logic signed [31:0] m, logic signed [31:0] g,
                                  bit typed = 0, logic signed [31:0] a = 0,
                                  logic signed [31:0] r = 0, logic b = 0);
    sample_row_t row;
    row.meas = m; row.gyro = g; row.typed = typed;
    row.res.angle = a; row.res.rate = r; row.res.bad = b;
    stim_rows.push_back(row);
  endfunction

  initial begin
    logic [38:0]        setting [5];
    logic signed [31:0] m, g;
    fused_t             none;
    int                 burst;
    none = '{default: '0};
    // reset asserted from time zero; the update lands after every process has started
    rst_ni <= 1'b0;
    in_ch.valid = 1'b0; in_ch.measured_angle = '0; in_ch.gyro_rate = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    reset_filter();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: first sample from reset state, then field extremes
    add_row(0, 0, 1, 0, 0, 1'b0);
    add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    add_row(-32'sh8000_0000, -32'sh8000_0000);
    add_row(32'sh7FFF_FFFF, -32'sh8000_0000);
    add_row(-32'sh8000_0000, 32'sh7FFF_FFFF);
    add_row(0, -32'sh8000_0000);
    add_row(-32'sh8000_0000, 0);
    add_row(1, -1);
    add_row(-1, 1);
    add_row(32'sh0001_0000, 32'sh0000_0100);
    add_row(-32'sh0001_0000, 32'sh5555_5555);
    add_row(32'shAAAA_AAAA, 32'sh2AAA_AAAA);
    add_row(0, 0);
    foreach (stim_rows[i])
      send_sample(stim_rows[i].meas, stim_rows[i].gyro, stim_rows[i].typed, stim_rows[i].res);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: setting = '{39'd21474836, 39'd4294967, 39'd12884902, 39'd2147483648,
                       39'h0_0001_0000};
        1: setting = '{39'h0_FFFF_FFFF, 39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFF,
                       39'h0_7FFF_FFFF};
        // zero gain and zero noise: innovation variance is zero, correction skipped
        2: setting = '{39'd0, 39'd0, 39'd0, 39'd0, 39'd0};
        3: setting = '{39'd1, 39'd0, 39'd0, 39'd1, 39'h0_8000_0000};
        default: begin
          setting[0] = 39'($urandom_range(1, 32'h0800_0000));
          setting[1] = 39'({$urandom_range(0, 127), $urandom} >> $urandom_range(0, 20));
          setting[2] = 39'({$urandom_range(0, 127), $urandom} >> $urandom_range(0, 20));
          setting[3] = 39'({$urandom_range(0, 127), $urandom} >> $urandom_range(0, 12));
          setting[4] = {7'd0, $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 32'h3_0000)
                                                   : 32'(  $urandom_range(0, 32'h3_0000))};
        end
      endcase
      write_reg(CFG_TIME_STEP, setting[0]);
      write_reg(CFG_ANGLE_NOISE, setting[1]);
      write_reg(CFG_BIAS_NOISE, setting[2]);
      write_reg(CFG_MEASURE_NOISE, setting[3]);
      write_reg(CFG_MEASURE_GAIN, setting[4]);
      // spare indexes must be ignored
      write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                39'({$urandom_range(0, 127), $urandom}));
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(20, 80);

      burst = $urandom_range(1, 8);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // mostly plausible IMU values, some full-range noise
        if ($urandom_range(0, 3) != 0) begin
          m = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
          g = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
        end else begin
          m = $urandom;
          g = $urandom;
        end
        send_sample(m, g, 0, none);
        if (n == ITEMS_PER_PHASE / 2) begin
          hold_off(0);
          wait (pending_results.size() == 0);
        end
        if (--burst == 0) begin
          burst = $urandom_range(1, 8);
          if (ph % 3 != 1) hold_off($urandom_range(0, 300));
        end
      end
      drain();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ angle_gyro_kalman_fusion.f @@
+incdir+sv
sv/agkf_pkg.sv
sv/agkf_if.sv
sv/agkf_mul.sv
sv/agkf_div.sv
sv/agkf_ctrl.sv
sv/agkf_dpath.sv
sv/angle_gyro_kalman_fusion.sv
tb/angle_gyro_kalman_fusion_tb.sv
